// ===== src/pgmap_pkg.sv =====
// Shared types and constants for the four-level page table mapper.
`default_nettype none

package pgmap_pkg;

    localparam int PT_TABLE_PAGES = 64;
    localparam int PT_ENTRIES     = 512;
    localparam int PT_IDX_W       = 9;
    localparam int PT_VA_W        = 48;
    localparam int PT_FRAME_W     = 40;
    localparam int PT_ENTRY_W     = 64;
    localparam int PT_LEAF_W      = 52;
    localparam int PT_USED_W      = 7;

    typedef enum logic [0:0] {
        OP_MAP   = 1'b0,
        OP_UNMAP = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_POOL = 2'd1,
        STAT_NO_MAP  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ALLOC,
        ST_LEAF,
        ST_UNMAP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    descend;
        logic    alloc;
        logic    wr_leaf;
        logic    wr_unmap;
        logic    fin;
        status_t fin_status;
    } pgmap_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       clr_last;
        logic       is_unmap;
        logic [1:0] level;
        logic       ok;
        logic       leaf_present;
        logic       fits;
    } pgmap_sts_t;

endpackage

`default_nettype wire

// ===== src/pgmap_dp.sv =====
// Datapath: table memory, request registers, walk pointer, allocator and results.
`default_nettype none

module pgmap_dp
    import pgmap_pkg::*;
#(
    parameter int TABLE_PAGES = PT_TABLE_PAGES
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pgmap_cmd_t            cmd,
    output pgmap_sts_t                 sts,
    input  wire logic                  op,
    input  wire logic [PT_VA_W-1:0]    vaddr,
    input  wire logic [PT_FRAME_W-1:0] phys_frame,
    input  wire logic                  writable,
    input  wire logic                  user,
    input  wire logic                  cfg_we,
    input  wire logic [PT_FRAME_W-1:0] cfg_wdata,
    output logic                       done,
    output logic [1:0]                 status,
    output logic                       invalidate,
    output logic [PT_LEAF_W-1:0]       leaf_value,
    output logic [PT_USED_W-1:0]       pages_used
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int NW    = $clog2(TABLE_PAGES + 1);
    localparam int AW    = PW + PT_IDX_W;
    localparam int DEPTH = TABLE_PAGES * PT_ENTRIES;

    logic [PT_ENTRY_W-1:0] mem [DEPTH];
    logic [PT_ENTRY_W-1:0] rdata_reg;

    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]         page_reg, page_next;
    logic [1:0]            lvl_reg, lvl_next;
    logic [NW-1:0]         free_reg, free_next;
    logic [PT_FRAME_W-1:0] base_reg;

    logic                  op_reg;
    logic [PT_IDX_W-1:0]   ix_reg [4];
    logic [PT_FRAME_W-1:0] frame_reg;
    logic                  wr_bit_reg;
    logic                  user_bit_reg;

    logic                  done_reg;
    logic [1:0]            status_reg;
    logic                  inval_reg;
    logic [PT_LEAF_W-1:0]  leaf_reg;
    logic [PT_USED_W-1:0]  used_reg;

    logic [AW-1:0]         mem_addr;
    logic                  mem_we;
    logic [PT_ENTRY_W-1:0] mem_wdata;
    logic [PT_FRAME_W-1:0] rel;
    logic [PT_FRAME_W-1:0] new_frame;
    logic [PT_ENTRY_W-1:0] ptr_entry;
    logic [PT_ENTRY_W-1:0] leaf_entry;
    logic [NW:0]           need_total;
    logic [NW+PT_USED_W-1:0] used_wide;

    // entry at {page, index of current level}; the clear sweep overrides it
    assign mem_addr   = cmd.clr_step ? clr_cnt_reg : {page_reg, ix_reg[lvl_reg]};
    assign new_frame  = base_reg + PT_FRAME_W'(free_reg);
    assign ptr_entry  = {12'h000, new_frame, 12'h007};
    assign leaf_entry = {12'h000, frame_reg, 9'h000, user_bit_reg, wr_bit_reg, 1'b1};
    assign mem_we     = cmd.clr_step | cmd.alloc | cmd.wr_leaf | cmd.wr_unmap;

    always_comb
    begin
        if (cmd.alloc)
        begin
            mem_wdata = ptr_entry;
        end
        else if (cmd.wr_leaf)
        begin
            mem_wdata = leaf_entry;
        end
        else
        begin
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // pointer is followed only if it lands on a page already handed out
    assign rel        = rdata_reg[51:12] - base_reg;
    assign need_total = {1'b0, free_reg} + (NW+1)'(2'd3 - lvl_reg);

    assign sts.clr_last     = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.is_unmap     = (op_reg == OP_UNMAP);
    assign sts.level        = lvl_reg;
    assign sts.ok           = rdata_reg[0] && (rel < PT_FRAME_W'(free_reg));
    assign sts.leaf_present = rdata_reg[0];
    assign sts.fits         = (need_total <= (NW+1)'(TABLE_PAGES));

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        page_next    = page_reg;
        lvl_next     = lvl_reg;
        free_next    = free_reg;
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end
        if (cmd.load)
        begin
            page_next = '0;
            lvl_next  = '0;
        end
        else if (cmd.descend)
        begin
            page_next = rel[PW-1:0];
            lvl_next  = lvl_reg + 2'd1;
        end
        else if (cmd.alloc)
        begin
            page_next = free_reg[PW-1:0];
            lvl_next  = lvl_reg + 2'd1;
            free_next = free_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            page_reg    <= '0;
            lvl_reg     <= '0;
            free_reg    <= NW'(1);
            base_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            page_reg    <= page_next;
            lvl_reg     <= lvl_next;
            free_reg    <= free_next;
            done_reg    <= cmd.fin;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    assign used_wide = {{PT_USED_W{1'b0}}, free_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            ix_reg[0]    <= vaddr[47:39];
            ix_reg[1]    <= vaddr[38:30];
            ix_reg[2]    <= vaddr[29:21];
            ix_reg[3]    <= vaddr[20:12];
            frame_reg    <= phys_frame;
            wr_bit_reg   <= writable;
            user_bit_reg <= user;
        end
        if (cmd.fin)
        begin
            status_reg <= cmd.fin_status;
            inval_reg  <= (cmd.fin_status == STAT_DONE);
            leaf_reg   <= ((cmd.fin_status == STAT_DONE) && (op_reg == OP_MAP))
                          ? leaf_entry[PT_LEAF_W-1:0] : '0;
            used_reg   <= used_wide[PT_USED_W-1:0];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign invalidate = inval_reg;
    assign leaf_value = leaf_reg;
    assign pages_used = used_reg;

endmodule

`default_nettype wire

// ===== src/pgmap_ctrl.sv =====
// Controller: clear sweep, table walk, allocation and leaf update sequencing.
`default_nettype none

module pgmap_ctrl
    import pgmap_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire pgmap_sts_t sts,
    output pgmap_cmd_t      cmd,
    output logic            busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.level == 2'd3)
                begin
                    state_next = sts.leaf_present ? ST_UNMAP : ST_IDLE;
                end
                else if (sts.ok)
                begin
                    state_next = (sts.level == 2'd2 && !sts.is_unmap) ? ST_LEAF : ST_READ;
                end
                else if (!sts.is_unmap && sts.fits)
                begin
                    state_next = ST_ALLOC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ALLOC:
            begin
                if (sts.level == 2'd2)
                begin
                    state_next = ST_LEAF;
                end
            end
            ST_LEAF:
            begin
                state_next = ST_IDLE;
            end
            ST_UNMAP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        cmd.fin_status = STAT_DONE;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_READ:
            begin
            end
            ST_EVAL:
            begin
                if (sts.level == 2'd3)
                begin
                    if (!sts.leaf_present)
                    begin
                        cmd.fin        = 1'b1;
                        cmd.fin_status = STAT_NO_MAP;
                    end
                end
                else if (sts.ok)
                begin
                    cmd.descend = 1'b1;
                end
                else if (sts.is_unmap)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = STAT_NO_MAP;
                end
                else if (!sts.fits)
                begin
                    cmd.fin        = 1'b1;
                    cmd.fin_status = STAT_NO_POOL;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc = 1'b1;
            end
            ST_LEAF:
            begin
                cmd.wr_leaf = 1'b1;
                cmd.fin     = 1'b1;
            end
            ST_UNMAP:
            begin
                cmd.wr_unmap = 1'b1;
                cmd.fin      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/four_level_page_table_mapper.sv =====
// Top level of the four-level page table mapper: controller plus datapath.
// Each request is sequenced over the single-port table memory: each level is a
// read followed by a check, and each new table and the leaf are then written.
// The block takes no new request while busy; the next start is taken in the done cycle.
// Reset: the table memory is swept to zero with busy high; the pool then holds
// only the root. Results cannot be stalled.
`default_nettype none

module four_level_page_table_mapper
    import pgmap_pkg::*;
#(
    parameter int TABLE_PAGES = PT_TABLE_PAGES  // pool size in 4 KiB tables
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [PT_VA_W-1:0]    vaddr,
    input  wire logic [PT_FRAME_W-1:0] phys_frame,
    input  wire logic                  writable,
    input  wire logic                  user,
    // pool base frame register
    input  wire logic                  cfg_we,
    input  wire logic [PT_FRAME_W-1:0] cfg_wdata,
    // result, valid for the single cycle that done is high
    output logic                       done,
    output logic [1:0]                 status,
    output logic                       invalidate,
    output logic [PT_LEAF_W-1:0]       leaf_value,
    output logic [PT_USED_W-1:0]       pages_used
);

    pgmap_cmd_t cmd;
    pgmap_sts_t sts;

    // The controller sequences the walk and holds the state register; the datapath
    // owns every other register and the table memory, and reports walk conditions back.
    pgmap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pgmap_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .vaddr      (vaddr),
        .phys_frame (phys_frame),
        .writable   (writable),
        .user       (user),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .invalidate (invalidate),
        .leaf_value (leaf_value),
        .pages_used (pages_used)
    );

    // An accepted request keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // The result strobe lands with the controller back in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // Every walk passes through the read and check states before it finishes, so done is a single-cycle pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Failed requests change nothing and report no leaf.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STAT_DONE) |-> (!invalidate && leaf_value == '0))
        else $error("error result carries a leaf or invalidate");

endmodule

`default_nettype wire

// ===== tb/sv/four_level_page_table_mapper_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the four-level page table mapper: directed table, then random walks.
module four_level_page_table_mapper_test;
    import pgmap_pkg::*;

    localparam int ENTRY_COUNT = PT_TABLE_PAGES * PT_ENTRIES;
    localparam int PHASE_REQS  = 260;   // random requests per pool-base setting
    localparam logic [PT_FRAME_W-1:0] FRAME_MAX = '1;
    localparam logic [PT_VA_W-1:0]    VA_MAX    = '1;

    // One result as the block reports it.
    typedef struct packed {
        status_t               status;
        logic                  invalidate;
        logic [PT_LEAF_W-1:0]  leaf;
        logic [PT_USED_W-1:0]  used;
    } walk_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    // Directed stimulus row. For ROW_CFG the frame field carries the new pool base.
    typedef struct {
        row_kind_t               kind;
        op_t                     op;
        logic [PT_VA_W-1:0]      va;
        logic [PT_FRAME_W-1:0]   frame;
        logic                    wr;
        logic                    usr;
        bit                      typed;    // compare against the typed result, not the model
        walk_result_t            result;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   op;
    logic [PT_VA_W-1:0]     vaddr;
    logic [PT_FRAME_W-1:0]  phys_frame;
    logic                   writable;
    logic                   user;
    logic                   cfg_we;
    logic [PT_FRAME_W-1:0]  cfg_wdata;
    logic                   done;
    logic [1:0]             status;
    logic                   invalidate;
    logic [PT_LEAF_W-1:0]   leaf_value;
    logic [PT_USED_W-1:0]   pages_used;

    // Shadow copy of the table pool, the bump allocator and the base register.
    logic [PT_ENTRY_W-1:0]  shadow_tables [0:ENTRY_COUNT-1];
    int                     shadow_next_free;
    logic [PT_FRAME_W-1:0]  shadow_base;

    walk_result_t           pending_results [$];
    stim_row_t              directed_rows [$];
    walk_result_t           seen_want;

    int                     fail_count;
    int                     mismatch_count;
    int                     idle_pct;

    // Index sets the random walks draw from; a few values per level keep the
    // tree small enough that the pool lasts through several base settings.
    logic [PT_IDX_W-1:0]    hot_top [0:1];
    logic [PT_IDX_W-1:0]    hot_mid [0:1];
    logic [PT_IDX_W-1:0]    hot_low;

    four_level_page_table_mapper #(
        .TABLE_PAGES(PT_TABLE_PAGES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .vaddr      (vaddr),
        .phys_frame (phys_frame),
        .writable   (writable),
        .user       (user),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .invalidate (invalidate),
        .leaf_value (leaf_value),
        .pages_used (pages_used)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walks the shadow tree for one request and applies its side effects.
    function automatic walk_result_t predict_walk(op_t req_op, logic [PT_VA_W-1:0] va,
                                                  logic [PT_FRAME_W-1:0] pf, logic wr,
                                                  logic usr);
        logic [PT_IDX_W-1:0]   ix [0:3];
        logic [PT_ENTRY_W-1:0] ent;
        logic [PT_FRAME_W-1:0] rel;
        int                    page;
        int                    lvl;
        int                    slot;
        walk_result_t          r;
        ix[0] = va[47:39];
        ix[1] = va[38:30];
        ix[2] = va[29:21];
        ix[3] = va[20:12];
        page = 0;
        lvl  = 0;
        r.status     = STAT_DONE;
        r.invalidate = 1'b0;
        r.leaf       = '0;
        // Follow present pointers. A pointer whose frame does not land on an
        // allocated pool page under the current base is stale: treat as absent.
        while (lvl < 3)
        begin
            ent = shadow_tables[page * PT_ENTRIES + ix[lvl]];
            rel = ent[51:12] - shadow_base;
            if (!ent[0] || rel >= PT_FRAME_W'(shadow_next_free))
                break;
            page = int'(rel);
            lvl++;
        end
        if (req_op == OP_MAP)
        begin
            // All-or-nothing: no table is taken unless the whole walk fits.
            if (shadow_next_free + 3 - lvl > PT_TABLE_PAGES)
                r.status = STAT_NO_POOL;
            else
            begin
                while (lvl < 3)
                begin
                    shadow_tables[page * PT_ENTRIES + ix[lvl]] =
                        {12'h000, shadow_base + PT_FRAME_W'(shadow_next_free), 12'h007};
                    page = shadow_next_free;
                    shadow_next_free++;
                    lvl++;
                end
                r.leaf = {pf, 9'd0, usr, wr, 1'b1};
                shadow_tables[page * PT_ENTRIES + ix[3]] = {12'h000, r.leaf};
                r.invalidate = 1'b1;
            end
        end
        else
        begin
            slot = page * PT_ENTRIES + ix[3];
            if (lvl == 3 && shadow_tables[slot][0])
            begin
                shadow_tables[slot] = '0;
                r.invalidate = 1'b1;
            end
            else
                r.status = STAT_NO_MAP;
        end
        r.used = PT_USED_W'(shadow_next_free);
        return r;
    endfunction

    function automatic void add_req(op_t o, logic [PT_VA_W-1:0] va, logic [PT_FRAME_W-1:0] pf,
                                    logic wr, logic usr, bit typed, status_t st, logic inv,
                                    logic [PT_LEAF_W-1:0] leaf, logic [PT_USED_W-1:0] used);
        stim_row_t row;
        row.kind              = ROW_REQ;
        row.op                = o;
        row.va                = va;
        row.frame             = pf;
        row.wr                = wr;
        row.usr               = usr;
        row.typed             = typed;
        row.result.status     = st;
        row.result.invalidate = inv;
        row.result.leaf       = leaf;
        row.result.used       = used;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [PT_FRAME_W-1:0] base);
        stim_row_t row;
        row.kind   = ROW_CFG;
        row.op     = OP_MAP;
        row.va     = '0;
        row.frame  = base;
        row.wr     = 1'b0;
        row.usr    = 1'b0;
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    // Presents one request, holds it until busy is low at a rising edge, then
    // records its expected result and maybe idles the request side a while.
    task automatic issue_request(op_t req_op, logic [PT_VA_W-1:0] va, logic [PT_FRAME_W-1:0] pf,
                                 logic wr, logic usr, bit typed, walk_result_t typed_result);
        walk_result_t predicted;
        @(negedge clk);
        op         <= req_op;
        vaddr      <= va;
        phys_frame <= pf;
        writable   <= wr;
        user       <= usr;
        start      <= 1'b1;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = predict_walk(req_op, va, pf, wr, usr);
        pending_results.push_back(typed ? typed_result : predicted);
        if ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(negedge clk);
        end
    endtask

    // Base register is only touched with no request in flight.
    task automatic write_pool_base(logic [PT_FRAME_W-1:0] base);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= base;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_base = base;
    endtask

    // Mostly walks over the hot index sets with random leaf slots, so remaps,
    // unmaps of live pages and shared intermediate tables are common; the rest
    // is noise over the whole address space, mostly unmaps of nothing.
    task automatic issue_random();
        logic [PT_VA_W-1:0]    va;
        logic [PT_FRAME_W-1:0] pf;
        logic [PT_IDX_W-1:0]   leaf_ix;
        op_t                   o;
        case ($urandom_range(15))
            0:       pf = '0;
            1:       pf = FRAME_MAX;
            default: pf = PT_FRAME_W'({$urandom, $urandom});
        endcase
        if ($urandom_range(9) == 0)
        begin
            va = PT_VA_W'({$urandom, $urandom});
            o  = ($urandom_range(9) == 0) ? OP_MAP : OP_UNMAP;
        end
        else
        begin
            if ($urandom_range(3) == 0)
                leaf_ix = PT_IDX_W'($urandom);
            else if ($urandom_range(1) == 0)
                leaf_ix = PT_IDX_W'($urandom_range(7));
            else
                leaf_ix = PT_IDX_W'($urandom_range(511, 504));
            va = {hot_top[$urandom_range(1)], hot_mid[$urandom_range(1)], hot_low, leaf_ix,
                  12'($urandom)};
            o  = ($urandom_range(99) < 55) ? OP_MAP : OP_UNMAP;
        end
        issue_request(o, va, pf, 1'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    // Result checker: every done strobe is matched against the oldest
    // expectation; results cannot be stalled so nothing is driven back.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (mismatch_count < 10)
                    $display("unexpected result, none pending: status %0d inv %0b leaf %h used %0d",
                             status, invalidate, leaf_value, pages_used);
                mismatch_count++;
            end
            else
            begin
                seen_want = pending_results.pop_front();
                if (status !== seen_want.status || invalidate !== seen_want.invalidate ||
                    leaf_value !== seen_want.leaf || pages_used !== seen_want.used)
                begin
                    fail_count++;
                    if (mismatch_count < 10)
                        $display({"result mismatch: expected status %0d inv %0b leaf %h ",
                                  "used %0d, got status %0d inv %0b leaf %h used %0d"},
                                 seen_want.status, seen_want.invalidate, seen_want.leaf,
                                 seen_want.used, status, invalidate, leaf_value, pages_used);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: covers the post-reset memory sweep plus the whole run many times.
    initial
    begin
        #5_000_000;
        $display("four_level_page_table_mapper_test failed");
        $finish;
    end

    initial
    begin
        logic [PT_FRAME_W-1:0] phase_base;
        rst_n      = 1'b0;
        start      = 1'b0;
        op         = OP_MAP;
        vaddr      = '0;
        phys_frame = '0;
        writable   = 1'b0;
        user       = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        fail_count     = 0;
        mismatch_count = 0;
        idle_pct       = 34;
        for (int i = 0; i < ENTRY_COUNT; i++)
            shadow_tables[i] = '0;
        shadow_next_free = 1;
        shadow_base      = '0;

        // Directed table. Typed rows: reset state, field extremes, error codes.
        // Empty pool after reset: unmap finds nothing.
        add_req(OP_UNMAP, '0, '0, 1'b0, 1'b0, 1'b1, STAT_NO_MAP, 1'b0, '0, 7'd1);
        // First map builds three tables; leaf is just the present bit.
        add_req(OP_MAP, '0, '0, 1'b0, 1'b0, 1'b1, STAT_DONE, 1'b1, 52'h1, 7'd4);
        // Remap with every leaf bit set.
        add_req(OP_MAP, '0, FRAME_MAX, 1'b1, 1'b1, 1'b1, STAT_DONE, 1'b1, 52'hFFFFFFFFFF007, 7'd4);
        add_req(OP_UNMAP, '0, FRAME_MAX, 1'b1, 1'b1, 1'b1, STAT_DONE, 1'b1, '0, 7'd4);
        // Leaf already cleared: unmap of an absent page.
        add_req(OP_UNMAP, '0, '0, 1'b0, 1'b0, 1'b1, STAT_NO_MAP, 1'b0, '0, 7'd4);
        add_req(OP_MAP, VA_MAX, FRAME_MAX, 1'b1, 1'b0, 1'b1, STAT_DONE, 1'b1, 52'hFFFFFFFFFF003,
                7'd7);
        add_req(OP_UNMAP, VA_MAX, '0, 1'b0, 1'b0, 1'b1, STAT_DONE, 1'b1, '0, 7'd7);
        // Shared paths: none, three and two new tables.
        add_req(OP_MAP, 48'h0000_0000_5000, 40'hA5_A5A5_A5A5, 1'b0, 1'b1, 1'b0, STAT_DONE, 1'b0, '0,
                '0);
        add_req(OP_MAP, 48'h0080_4020_1000, 40'h00_0000_0001, 1'b1, 1'b1, 1'b0, STAT_DONE, 1'b0, '0,
                '0);
        add_req(OP_MAP, 48'h0000_4000_0000, 40'h5A_5A5A_5A5A, 1'b1, 1'b0, 1'b0, STAT_DONE, 1'b0, '0,
                '0);
        // Tables present, leaf slot empty.
        add_req(OP_UNMAP, 48'h0000_0000_7ABC, '0, 1'b0, 1'b0, 1'b1, STAT_NO_MAP, 1'b0, '0, 7'd12);
        // Shifted base: the top pointer goes stale, then map replaces it.
        add_cfg(40'd5);
        add_req(OP_UNMAP, VA_MAX, '0, 1'b0, 1'b0, 1'b1, STAT_NO_MAP, 1'b0, '0, 7'd12);
        add_req(OP_MAP, VA_MAX, 40'h1, 1'b0, 1'b0, 1'b0, STAT_DONE, 1'b0, '0, '0);
        add_cfg('0);
        add_req(OP_UNMAP, VA_MAX, '0, 1'b0, 1'b0, 1'b0, STAT_DONE, 1'b0, '0, '0);
        add_req(OP_MAP, 48'h0000_0000_0FFF, '0, 1'b1, 1'b1, 1'b0, STAT_DONE, 1'b0, '0, '0);
        // Base at its top: pointer frames wrap around 40 bits.
        add_cfg(FRAME_MAX);
        add_req(OP_MAP, 48'h5555_5555_5000, 40'h55_5555_5555, 1'b1, 1'b0, 1'b0, STAT_DONE, 1'b0, '0,
                '0);
        add_req(OP_UNMAP, 48'h5555_5555_5000, '0, 1'b0, 1'b0, 1'b0, STAT_DONE, 1'b0, '0, '0);
        add_req(OP_MAP, 48'hAAAA_AAAA_AFFF, 40'hAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, STAT_DONE, 1'b0, '0,
                '0);
        add_cfg('0);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // The block sweeps its table memory first; issue_request waits on busy.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_pool_base(directed_rows[i].frame);
            else
                issue_request(directed_rows[i].op, directed_rows[i].va, directed_rows[i].frame,
                              directed_rows[i].wr, directed_rows[i].usr, directed_rows[i].typed,
                              directed_rows[i].result);
        end

        // Random phases. Base 0, then its top, then a random base, then 0 again so
        // the first trees come back and the pool runs dry.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    phase_base = '0;
                    idle_pct   = 34;
                end
                1:
                begin
                    phase_base = FRAME_MAX;
                    idle_pct   = 75;
                end
                2:
                begin
                    phase_base = PT_FRAME_W'({$urandom, $urandom});
                    idle_pct   = 0;
                end
                default:
                begin
                    phase_base = '0;
                    idle_pct   = 0;
                end
            endcase
            if (ph == 2)
            begin
                hot_top[0] = PT_IDX_W'($urandom);
                hot_top[1] = PT_IDX_W'($urandom);
                hot_mid[0] = PT_IDX_W'($urandom);
                hot_mid[1] = PT_IDX_W'($urandom);
                hot_low    = PT_IDX_W'($urandom);
            end
            else
            begin
                hot_top[0] = '0;
                hot_top[1] = '1;
                hot_mid[0] = '0;
                hot_mid[1] = '1;
                hot_low    = '1;
            end
            write_pool_base(phase_base);
            repeat (PHASE_REQS)
                issue_random();
        end

        // Drain, then allow the longest walk for any stray strobe.
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("four_level_page_table_mapper_test passed");
        else
            $display("four_level_page_table_mapper_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/pgmap_pkg.sv
src/pgmap_dp.sv
src/pgmap_ctrl.sv
src/four_level_page_table_mapper.sv
tb/sv/four_level_page_table_mapper_test.sv
